// ===== rtl/core/dfsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfsm_pkg
// Shared types and constants for the drive fault and speed monitor.
// ----------------------------------------------------------------------------
package dfsm_pkg;

  localparam int unsigned VW = 10;  // sample and limit width
  localparam int unsigned FW = 6;   // frequency width
  localparam int unsigned CW = 3;   // config index width

  localparam logic [3:0]    LOW_TRIP  = 4'd10;
  localparam logic [2:0]    HIGH_TRIP = 3'd4;
  localparam logic [FW-1:0] FREQ_MIN  = 6'd5;
  localparam logic [FW-1:0] FREQ_MAX  = 6'd55;

  // config register indexes
  localparam logic [CW-1:0] REG_LOW_LIMIT  = 3'd0;
  localparam logic [CW-1:0] REG_XLOW_LIMIT = 3'd1;
  localparam logic [CW-1:0] REG_HIGH_LIMIT = 3'd2;
  localparam logic [CW-1:0] REG_CUR_LIMIT  = 3'd3;

  localparam logic [VW-1:0] LOW_LIMIT_RST  = 10'd300;
  localparam logic [VW-1:0] XLOW_LIMIT_RST = 10'd200;
  localparam logic [VW-1:0] HIGH_LIMIT_RST = 10'd900;
  localparam logic [VW-1:0] CUR_LIMIT_RST  = 10'd900;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_BUS     = 3'd1;
  localparam logic [2:0] ERR_SHORT   = 3'd2;
  localparam logic [2:0] ERR_XLOW    = 3'd3;
  localparam logic [2:0] ERR_CURRENT = 3'd4;

  typedef enum logic [2:0] {
    FUNC_VOLT    = 3'd0,
    FUNC_CURRENT = 3'd1,
    FUNC_SHORT   = 3'd2,
    FUNC_LOGIC   = 3'd3,
    FUNC_BUTTONS = 3'd4
  } func_t;

  typedef struct packed {
    logic [VW-1:0] low_limit;
    logic [VW-1:0] xlow_limit;
    logic [VW-1:0] high_limit;
    logic [VW-1:0] cur_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]    func;
    logic [VW-1:0] bus_voltage;
    logic [VW-1:0] bus_current;
    logic          short_pin;
    logic          logic_pin;
    logic          up_button_n;
    logic          down_button_n;
    logic          start_button_n;
    logic          mode_pin;
  } item_t;

  typedef struct packed {
    logic [3:0]    low_count;
    logic [1:0]    high_count;
    logic          f_low;
    logic          f_xlow;
    logic          f_high;
    logic          f_cur;
    logic          f_short_latch;
    logic          f_short;
    logic          f_logic;
    logic [2:0]    error_reg;
    logic          lamp;
    logic [FW-1:0] set_frequency;
    logic          run_flag;
    logic          auto_mode;
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/dfsm_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfsm_cfg_regs
// Threshold register file, written through the plain write port.
// ----------------------------------------------------------------------------
module dfsm_cfg_regs
  import dfsm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [CW-1:0] cfg_index,
  input  wire logic [VW-1:0] cfg_data,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_limit  <= LOW_LIMIT_RST;
      cfg.xlow_limit <= XLOW_LIMIT_RST;
      cfg.high_limit <= HIGH_LIMIT_RST;
      cfg.cur_limit  <= CUR_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_LIMIT:  cfg.low_limit  <= cfg_data;
        REG_XLOW_LIMIT: cfg.xlow_limit <= cfg_data;
        REG_HIGH_LIMIT: cfg.high_limit <= cfg_data;
        REG_CUR_LIMIT:  cfg.cur_limit  <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/dfsm_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfsm_step
// Next-state logic for one check word: voltage qualification, direct fault
// compares and the manual frequency / start buttons.
// ----------------------------------------------------------------------------
module dfsm_step
  import dfsm_pkg::*;
(
  input  wire cfg_t   cfg,
  input  wire item_t  item,
  input  wire state_t st,
  output state_t      st_next,
  output logic        strobe
);

  logic          lc, xc, hc;
  logic [4:0]    low_inc;
  logic [2:0]    high_inc;
  logic [FW:0]   freq_inc;
  logic [FW-1:0] freq;

  always_comb begin
    st_next  = st;
    strobe   = 1'b0;
    lc       = item.bus_voltage <= cfg.low_limit;
    xc       = item.bus_voltage <= cfg.xlow_limit;
    hc       = item.bus_voltage >= cfg.high_limit;
    low_inc  = {1'b0, st.low_count} + 5'd1;
    high_inc = {1'b0, st.high_count} + 3'd1;
    freq_inc = {1'b0, st.set_frequency} + 7'd1;
    freq     = st.set_frequency;

    case (item.func)
      FUNC_VOLT: begin
        // lamp and error code follow the check order, last write wins
        if (lc) begin
          if (low_inc >= {1'b0, LOW_TRIP}) begin
            st_next.low_count = 4'd0;
            st_next.f_low     = 1'b1;
            st_next.error_reg = ERR_BUS;
            st_next.lamp      = ~st_next.lamp;
          end else begin
            st_next.low_count = low_inc[3:0];
          end
        end else begin
          st_next.f_low     = 1'b0;
          st_next.low_count = 4'd0;
          st_next.lamp      = 1'b0;
        end
        if (xc) begin
          st_next.f_xlow    = 1'b1;
          st_next.error_reg = ERR_XLOW;
          st_next.lamp      = ~st_next.lamp;
        end else begin
          st_next.f_xlow = 1'b0;
          st_next.lamp   = 1'b0;
        end
        if (hc) begin
          if (high_inc >= HIGH_TRIP) begin
            st_next.high_count = 2'd0;
            st_next.f_high     = 1'b1;
            st_next.error_reg  = ERR_BUS;
            st_next.lamp       = ~st_next.lamp;
          end else begin
            st_next.high_count = high_inc[1:0];
          end
        end else begin
          st_next.f_high     = 1'b0;
          st_next.high_count = 2'd0;
          st_next.lamp       = 1'b0;
        end
        if (item.short_pin) begin
          st_next.error_reg     = ERR_SHORT;
          st_next.f_short_latch = 1'b1;
          st_next.lamp          = ~st_next.lamp;
        end
      end
      FUNC_CURRENT: begin
        if (item.bus_current >= cfg.cur_limit) begin
          st_next.f_cur     = 1'b1;
          st_next.error_reg = ERR_CURRENT;
          st_next.lamp      = ~st.lamp;
        end else begin
          st_next.f_cur = 1'b0;
          st_next.lamp  = 1'b0;
        end
      end
      FUNC_SHORT: begin
        if (item.short_pin) begin
          st_next.f_short   = 1'b1;
          st_next.error_reg = ERR_SHORT;
          st_next.lamp      = ~st.lamp;
        end else begin
          st_next.f_short = 1'b0;
          st_next.lamp    = 1'b0;
        end
      end
      FUNC_LOGIC: begin
        if (item.logic_pin) begin
          st_next.f_logic = 1'b1;
          st_next.lamp    = ~st.lamp;
        end else begin
          st_next.f_logic = 1'b0;
          st_next.lamp    = 1'b0;
        end
      end
      FUNC_BUTTONS: begin
        // button logic sees the old mode; mode is sampled afterwards
        if (!item.up_button_n && item.start_button_n && !st.auto_mode) begin
          freq   = (freq_inc >= {1'b0, FREQ_MAX}) ? FREQ_MAX : freq_inc[FW-1:0];
          strobe = 1'b1;
        end
        if (!item.down_button_n && !st.auto_mode) begin
          freq   = (freq <= FREQ_MIN + 6'd1) ? FREQ_MIN : freq - 6'd1;
          strobe = 1'b1;
        end
        st_next.set_frequency = freq;
        if (!st.auto_mode && !item.start_button_n && !item.up_button_n &&
            !st.f_low && !st.f_high && !st.f_cur && !st.run_flag) begin
          st_next.run_flag = 1'b1;
          strobe           = 1'b1;
        end
        st_next.auto_mode = item.mode_pin;
      end
      default: ;  // unused check code, state held
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/drive_fault_and_speed_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drive_fault_and_speed_monitor
// Motor-drive supervisor: bus voltage qualification, fault flags, fault lamp,
// manual frequency buttons and start.
// ----------------------------------------------------------------------------
// One check word in, one status word out. A word is captured in an input
// register, then evaluated combinationally against the supervisor state and
// written to the output register together with the updated state. A new word
// is taken every cycle as long as the output side keeps up. Thresholds come
// from four 10-bit registers on the write port; write them only while no word
// is in flight.
module drive_fault_and_speed_monitor
  import dfsm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,

  input  wire logic          cfg_we,
  input  wire logic [CW-1:0] cfg_index,
  input  wire logic [VW-1:0] cfg_data,

  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    func,
  input  wire logic [VW-1:0] bus_voltage,
  input  wire logic [VW-1:0] bus_current,
  input  wire logic          short_pin,
  input  wire logic          logic_pin,
  input  wire logic          up_button_n,
  input  wire logic          down_button_n,
  input  wire logic          start_button_n,
  input  wire logic          mode_pin,

  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               low_fault,
  output logic               extreme_low_fault,
  output logic               high_fault,
  output logic               current_fault,
  output logic               short_latched,
  output logic               short_fault,
  output logic               logic_fault,
  output logic [2:0]         error_code,
  output logic               indicator,
  output logic [FW-1:0]      frequency,
  output logic               running,
  output logic               recompute
);

  cfg_t   cfg;
  item_t  s1_item;
  logic   s1_valid;
  logic   s2_adv;
  state_t st, st_next;
  logic   strobe;

  dfsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dfsm_step u_step (
    .cfg     (cfg),
    .item    (s1_item),
    .st      (st),
    .st_next (st_next),
    .strobe  (strobe)
  );

  assign s2_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s2_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= '{func, bus_voltage, bus_current, short_pin, logic_pin,
                   up_button_n, down_button_n, start_button_n, mode_pin};
    end
  end

  // supervisor state, updated as the word moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{low_count: 4'd0, high_count: 2'd0, f_low: 1'b0, f_xlow: 1'b0,
              f_high: 1'b0, f_cur: 1'b0, f_short_latch: 1'b0, f_short: 1'b0,
              f_logic: 1'b0, error_reg: ERR_NONE, lamp: 1'b0,
              set_frequency: FREQ_MIN, run_flag: 1'b0, auto_mode: 1'b1};
    end else if (s2_adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      low_fault         <= st_next.f_low;
      extreme_low_fault <= st_next.f_xlow;
      high_fault        <= st_next.f_high;
      current_fault     <= st_next.f_cur;
      short_latched     <= st_next.f_short_latch;
      short_fault       <= st_next.f_short;
      logic_fault       <= st_next.f_logic;
      error_code        <= st_next.error_reg;
      indicator         <= st_next.lamp;
      frequency         <= st_next.set_frequency;
      running           <= st_next.run_flag;
      recompute         <= strobe;
    end
  end

  // stall only when both stages hold a word the sink has not taken
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a full pipe");

  a_freq_range: assert property (@(posedge clk) disable iff (rst)
    (st.set_frequency >= FREQ_MIN) && (st.set_frequency <= FREQ_MAX))
    else $error("set frequency out of range");

  a_low_count: assert property (@(posedge clk) disable iff (rst)
    st.low_count < LOW_TRIP)
    else $error("low count past trip level");

  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !s2_adv) |=> !out_valid)
    else $error("output word repeated");

  a_run_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(st.run_flag) |-> st.run_flag)
    else $error("running flag dropped");

endmodule
`default_nettype wire

// ===== dv/tb_drive_fault_and_speed_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drive_fault_and_speed_monitor
// Self-checking bench for the drive supervisor. A queue-fed driver pushes check
// words over valid/ready, a clocked predictor tracks the supervisor state and
// queues the expected status word for each accepted check, and the monitor
// compares every returned status word field by field. Threshold registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_drive_fault_and_speed_monitor;
  import dfsm_pkg::*;

  typedef struct packed {
    logic          low;
    logic          xlow;
    logic          high;
    logic          cur;
    logic          sc_latch;
    logic          sc;
    logic          lerr;
    logic [2:0]    err;
    logic          lamp;
    logic [FW-1:0] freq;
    logic          run;
    logic          recomp;
  } status_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [CW-1:0] cfg_index = '0;
  logic [VW-1:0] cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  item_t         in_word = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          low_fault, extreme_low_fault, high_fault, current_fault;
  logic          short_latched, short_fault, logic_fault;
  logic [2:0]    error_code;
  logic          indicator;
  logic [FW-1:0] frequency;
  logic          running, recompute;

  item_t   pending_words[$];
  status_t status_q[$];
  int      n_err = 0;
  int      n_checks = 0;
  bit      no_idle = 1'b0;

  // predicted supervisor state and thresholds
  logic [VW-1:0] lim_low = LOW_LIMIT_RST;
  logic [VW-1:0] lim_xlow = XLOW_LIMIT_RST;
  logic [VW-1:0] lim_high = HIGH_LIMIT_RST;
  logic [VW-1:0] lim_cur = CUR_LIMIT_RST;
  logic [3:0]    low_cnt = '0;
  logic [1:0]    high_cnt = '0;
  logic          f_low = 1'b0, f_xlow = 1'b0, f_high = 1'b0, f_cur = 1'b0;
  logic          f_sc_latch = 1'b0, f_sc = 1'b0, f_lerr = 1'b0;
  logic [2:0]    err_code = ERR_NONE;
  logic          lamp = 1'b0;
  logic [FW-1:0] freq_set = FREQ_MIN;
  logic          run_on = 1'b0;
  logic          auto_on = 1'b1;

  drive_fault_and_speed_monitor u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .func              (in_word.func),
    .bus_voltage       (in_word.bus_voltage),
    .bus_current       (in_word.bus_current),
    .short_pin         (in_word.short_pin),
    .logic_pin         (in_word.logic_pin),
    .up_button_n       (in_word.up_button_n),
    .down_button_n     (in_word.down_button_n),
    .start_button_n    (in_word.start_button_n),
    .mode_pin          (in_word.mode_pin),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .low_fault         (low_fault),
    .extreme_low_fault (extreme_low_fault),
    .high_fault        (high_fault),
    .current_fault     (current_fault),
    .short_latched     (short_latched),
    .short_fault       (short_fault),
    .logic_fault       (logic_fault),
    .error_code        (error_code),
    .indicator         (indicator),
    .frequency         (frequency),
    .running           (running),
    .recompute         (recompute)
  );

  always #5 clk = ~clk;

  // Apply one accepted check word to the predicted state, queue the status.
  task automatic advance_supervisor(input item_t w);
    logic [4:0] nl;
    logic [2:0] nh;
    logic [6:0] nf;
    logic       strobe;
    status_t    s;
    strobe = 1'b0;
    case (w.func)
      FUNC_VOLT: begin
        if (w.bus_voltage <= lim_low) begin
          nl = low_cnt + 5'd1;
          if (nl >= LOW_TRIP) begin
            nl = '0; f_low = 1'b1; err_code = ERR_BUS; lamp = ~lamp;
          end
          low_cnt = nl[3:0];
        end else begin
          f_low = 1'b0; low_cnt = '0; lamp = 1'b0;
        end
        if (w.bus_voltage <= lim_xlow) begin
          f_xlow = 1'b1; err_code = ERR_XLOW; lamp = ~lamp;
        end else begin
          f_xlow = 1'b0; lamp = 1'b0;
        end
        if (w.bus_voltage >= lim_high) begin
          nh = high_cnt + 3'd1;
          if (nh >= HIGH_TRIP) begin
            nh = '0; f_high = 1'b1; err_code = ERR_BUS; lamp = ~lamp;
          end
          high_cnt = nh[1:0];
        end else begin
          f_high = 1'b0; high_cnt = '0; lamp = 1'b0;
        end
        if (w.short_pin) begin
          err_code = ERR_SHORT; f_sc_latch = 1'b1; lamp = ~lamp;
        end
      end
      FUNC_CURRENT: begin
        if (w.bus_current >= lim_cur) begin
          f_cur = 1'b1; err_code = ERR_CURRENT; lamp = ~lamp;
        end else begin
          f_cur = 1'b0; lamp = 1'b0;
        end
      end
      FUNC_SHORT: begin
        if (w.short_pin) begin
          err_code = ERR_SHORT; f_sc = 1'b1; lamp = ~lamp;
        end else begin
          f_sc = 1'b0; lamp = 1'b0;
        end
      end
      FUNC_LOGIC: begin
        if (w.logic_pin) begin
          f_lerr = 1'b1; lamp = ~lamp;
        end else begin
          f_lerr = 1'b0; lamp = 1'b0;
        end
      end
      FUNC_BUTTONS: begin
        // a start press holds up low, so up only steps with start released
        if (!w.up_button_n && w.start_button_n && !auto_on) begin
          nf = freq_set + 7'd1;
          if (nf >= FREQ_MAX) nf = {1'b0, FREQ_MAX};
          freq_set = nf[FW-1:0];
          strobe = 1'b1;
        end
        if (!w.down_button_n && !auto_on) begin
          freq_set = (freq_set <= FREQ_MIN + 6'd1) ? FREQ_MIN : freq_set - 6'd1;
          strobe = 1'b1;
        end
        if (!auto_on && !w.start_button_n && !w.up_button_n &&
            !f_low && !f_high && !f_cur && !run_on) begin
          run_on = 1'b1; strobe = 1'b1;
          f_cur = 1'b0; f_low = 1'b0; f_high = 1'b0;
        end
        auto_on = w.mode_pin;  // mode follows the button logic
      end
      default: ;
    endcase
    s = '{low: f_low, xlow: f_xlow, high: f_high, cur: f_cur, sc_latch: f_sc_latch,
          sc: f_sc, lerr: f_lerr, err: err_code, lamp: lamp, freq: freq_set,
          run: run_on, recomp: strobe};
    status_q.push_back(s);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_err++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) advance_supervisor(in_word);
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && (no_idle || $urandom_range(99) >= 7)) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    status_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $error("status word with no check pending");
          n_err++;
        end else begin
          e = status_q.pop_front();
          check_field("low_fault", e.low, low_fault);
          check_field("extreme_low_fault", e.xlow, extreme_low_fault);
          check_field("high_fault", e.high, high_fault);
          check_field("current_fault", e.cur, current_fault);
          check_field("short_latched", e.sc_latch, short_latched);
          check_field("short_fault", e.sc, short_fault);
          check_field("logic_fault", e.lerr, logic_fault);
          check_field("error_code", e.err, error_code);
          check_field("indicator", e.lamp, indicator);
          check_field("frequency", e.freq, frequency);
          check_field("running", e.run, running);
          check_field("recompute", e.recomp, recompute);
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= 7);
    end
  end

  task automatic queue_word(input item_t w);
    pending_words.push_back(w);
    if (w.func <= FUNC_BUTTONS) n_checks++;
  endtask

  function automatic item_t rand_word();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(item_t)-1:0];
  endfunction

  task automatic send_word(input logic [2:0] f, input int v, input int c,
                           input bit sp, input bit lp, input bit up_n,
                           input bit dn_n, input bit st_n, input bit md);
    item_t w;
    w = '{func: f, bus_voltage: VW'(v), bus_current: VW'(c), short_pin: sp,
          logic_pin: lp, up_button_n: up_n, down_button_n: dn_n,
          start_button_n: st_n, mode_pin: md};
    queue_word(w);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || status_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CW-1:0] idx, input logic [VW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LOW_LIMIT:  lim_low = val;
      REG_XLOW_LIMIT: lim_xlow = val;
      REG_HIGH_LIMIT: lim_high = val;
      REG_CUR_LIMIT:  lim_cur = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [VW-1:0] lo, input logic [VW-1:0] xl,
                            input logic [VW-1:0] hi, input logic [VW-1:0] cu);
    wait_drained();
    repeat (3) @(posedge clk);
    write_reg(REG_LOW_LIMIT, lo);
    write_reg(REG_XLOW_LIMIT, xl);
    write_reg(REG_HIGH_LIMIT, hi);
    write_reg(REG_CUR_LIMIT, cu);
  endtask

  task automatic set_ordered_limits();
    int a;
    a = $urandom_range(1023);
    set_limits(VW'(a), VW'($urandom_range(0, a)), VW'($urandom_range(a, 1023)),
               VW'($urandom_range(1023)));
  endtask

  // 0 extreme low, 1 low, 2 high, 3 normal, else anything
  function automatic int volt_for(input int cls);
    case (cls)
      0: return $urandom_range(0, lim_xlow);
      1: return (lim_low > lim_xlow) ? $urandom_range(lim_xlow + 1, lim_low)
                                     : $urandom_range(0, lim_low);
      2: return $urandom_range(lim_high, 1023);
      3: return (lim_high > lim_low + 1) ? $urandom_range(lim_low + 1, lim_high - 1)
                                         : $urandom_range(1023);
      default: return $urandom_range(1023);
    endcase
  endfunction

  task automatic gen_sequence();
    item_t w;
    int    kind, cls, len, lo, hi;
    bit    up_bias;
    kind = $urandom_range(99);
    if (kind < 35) begin
      // voltage runs long enough to qualify low and high levels
      cls = $urandom_range(4);
      len = $urandom_range(1, 14);
      for (int i = 0; i < len; i++) begin
        w = rand_word();
        w.func = FUNC_VOLT;
        w.bus_voltage = VW'(volt_for(($urandom_range(9) == 0) ? $urandom_range(4) : cls));
        w.short_pin = ($urandom_range(15) == 0);
        queue_word(w);
        if ($urandom_range(5) == 0) begin
          w = rand_word();
          w.func = 3'($urandom_range(FUNC_CURRENT, FUNC_BUTTONS));
          queue_word(w);
        end
      end
    end else if (kind < 55) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      up_bias = ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
        w = rand_word();
        w.func = FUNC_BUTTONS;
        w.up_button_n = !(up_bias ? ($urandom_range(99) < 70) : ($urandom_range(99) < 15));
        w.down_button_n = !(up_bias ? ($urandom_range(99) < 10) : ($urandom_range(99) < 70));
        w.start_button_n = !($urandom_range(9) == 0);
        w.mode_pin = ($urandom_range(19) == 0);
        queue_word(w);
      end
    end else if (kind < 85) begin
      w = rand_word();
      w.func = 3'($urandom_range(FUNC_CURRENT, FUNC_LOGIC));
      if (w.func == FUNC_CURRENT && $urandom_range(1)) begin
        lo = (lim_cur > 8) ? lim_cur - 8 : 0;
        hi = (lim_cur < 1015) ? lim_cur + 8 : 1023;
        w.bus_current = VW'($urandom_range(lo, hi));
      end
      queue_word(w);
    end else begin
      queue_word(rand_word());  // anything, unused check codes included
    end
  endtask

  task automatic run_random(input int target);
    int base;
    base = n_checks;
    while (n_checks - base < target / 2) gen_sequence();
    wait_drained();  // sender holds off until every status is back
    while (n_checks - base < target) gen_sequence();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_limits(LOW_LIMIT_RST, XLOW_LIMIT_RST, HIGH_LIMIT_RST, CUR_LIMIT_RST);
    send_word(3'(FUNC_BUTTONS + 1), 512, 512, 1, 1, 0, 0, 0, 0);
    send_word(3'(FUNC_BUTTONS + 3), 1023, 1023, 1, 1, 1, 1, 1, 1);
    repeat (4) send_word(FUNC_VOLT, 1023, 0, 0, 0, 1, 1, 1, 1);
    // start pressed in automatic mode, then blocked by the high fault
    send_word(FUNC_BUTTONS, 500, 0, 0, 0, 0, 1, 0, 0);
    send_word(FUNC_BUTTONS, 500, 0, 0, 0, 0, 1, 0, 0);
    send_word(FUNC_VOLT, 500, 0, 0, 0, 1, 1, 1, 0);
    send_word(FUNC_VOLT, 0, 0, 1, 0, 1, 1, 1, 0);
    send_word(FUNC_CURRENT, 0, 1023, 0, 0, 1, 1, 1, 0);
    send_word(FUNC_CURRENT, 0, 0, 0, 0, 1, 1, 1, 0);
    send_word(FUNC_SHORT, 0, 0, 1, 0, 1, 1, 1, 0);
    send_word(FUNC_SHORT, 0, 0, 0, 0, 1, 1, 1, 0);
    send_word(FUNC_LOGIC, 0, 0, 0, 1, 1, 1, 1, 0);
    send_word(FUNC_LOGIC, 0, 0, 0, 0, 1, 1, 1, 0);
    send_word(FUNC_BUTTONS, 0, 0, 0, 0, 0, 1, 0, 0);
    send_word(FUNC_BUTTONS, 0, 0, 0, 0, 0, 1, 0, 0);
    send_word(FUNC_BUTTONS, 0, 0, 0, 0, 1, 1, 0, 0);
    send_word(FUNC_BUTTONS, 0, 0, 0, 0, 0, 1, 1, 0);
    send_word(FUNC_BUTTONS, 0, 0, 0, 0, 0, 0, 1, 0);
    send_word(FUNC_BUTTONS, 0, 0, 0, 0, 1, 0, 1, 0);
    send_word(FUNC_BUTTONS, 0, 0, 0, 0, 1, 1, 1, 1);
    send_word(3'(FUNC_BUTTONS + 2), 0, 0, 0, 0, 0, 0, 0, 0);
    run_random(175);

    set_limits('0, '0, '0, '0);
    run_random(175);

    set_limits('1, '1, '1, '1);
    run_random(175);

    set_ordered_limits();
    no_idle = 1'b1;
    run_random(175);
    wait_drained();
    no_idle = 1'b0;

    set_limits(VW'($urandom_range(1023)), VW'($urandom_range(1023)),
               VW'($urandom_range(1023)), VW'($urandom_range(1023)));
    write_reg(CW'($urandom_range(REG_CUR_LIMIT + 1, (1 << CW) - 1)),
              VW'($urandom_range(1023)));
    run_random(175);

    set_ordered_limits();
    run_random(175);

    wait_drained();
    repeat (8) @(posedge clk);
    if (n_err == 0) begin
      $display("[drive_fault_and_speed_monitor] OK");
    end else begin
      $display("[drive_fault_and_speed_monitor] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[drive_fault_and_speed_monitor] ERROR");
    $finish;
  end

endmodule
